// File: design/gregorian_date_counter_top_defines.svh
// ----------------------------------------------------------------------------
// Gregorian date counter assertion macros
// Shared concurrent assertion forms for the date counter design.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_COUNTER_TOP_DEFINES_SVH
`define GREGORIAN_DATE_COUNTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define GDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/gdc_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date counter package
// Types, codes and calendar helper functions shared by the date counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdc_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 12;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_LOAD = 2'd1,
		ACT_CMP  = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	localparam logic [1:0] ORD_LESS = 2'd0;
	localparam logic [1:0] ORD_EQ   = 2'd1;
	localparam logic [1:0] ORD_GT   = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_REJECT   = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0] DAYS_28   = 5'd28;
	localparam logic [DAY_W-1:0] DAYS_29   = 5'd29;
	localparam logic [DAY_W-1:0] DAYS_30   = 5'd30;
	localparam logic [DAY_W-1:0] DAYS_31   = 5'd31;

	localparam logic [YEAR_W-1:0] YEAR_FIRST = 12'd1;

	// multiplicative inverse of 25 modulo 2**12, and the largest multiple index
	localparam logic [YEAR_W-1:0] INV25     = 12'd3113;
	localparam logic [YEAR_W-1:0] DIV25_MAX = 12'd163;

	typedef struct packed {
		action_t              action;
		logic [DAY_W-1:0]     day;
		logic [MONTH_W-1:0]   month;
		logic [YEAR_W-1:0]    year;
		logic                 load_ok;
	} gdc_item_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] p;
		logic              d4;
		logic              d16;
		logic              d25;
		p   = YEAR_W'(y * INV25);
		d25 = (p <= DIV25_MAX);
		d4  = (y[1:0] == 2'b00);
		d16 = (y[3:0] == 4'b0000);
		return (d4 & ~d25) | (d16 & d25);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_30;
			MON_FEB: len = leap ? DAYS_29 : DAYS_28;
			default: len = DAYS_31;
		endcase
		return len;
	endfunction

endpackage

// File: design/gregorian_date_counter_top.sv
// ----------------------------------------------------------------------------
// Gregorian date counter
// Calendar date register with day tick, checked load and date compare.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one beat: action, day_in, month_in,
// year_in. Action 0 ticks one day, 1 loads a checked date, 2 compares the
// stored date with the given one, 3 does nothing.
// Output channel out_valid/out_ready returns one beat per input beat: the
// stored date after the step, order_code and status.
// An accepted beat is captured by the input register and then moves to the
// result register when the core advances. Throughput is one beat per cycle
// while the receiver does not stall; the stored date updates in the same cycle
// as the result register, so back-to-back beats see each other's effect.
// Reset clears both valid flags and sets the stored date to 1.1.1.
// When the receiver stalls, the result holds, the input register keeps one
// more beat, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gregorian_date_counter_top_defines.svh"

module gregorian_date_counter_top
	import gdc_pkg::*;
#(
	parameter int unsigned MAX_YEAR = 3000
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [DAY_W-1:0]    day_in,
	input  logic [MONTH_W-1:0]  month_in,
	input  logic [YEAR_W-1:0]   year_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DAY_W-1:0]    day_out,
	output logic [MONTH_W-1:0]  month_out,
	output logic [YEAR_W-1:0]   year_out,
	output logic [1:0]          order_code,
	output logic [1:0]          status
);

	localparam logic [YEAR_W-1:0] YEAR_LAST = YEAR_W'(MAX_YEAR);

	logic      valid_s1;
	gdc_item_t item_s1;
	logic      advance;

	gdc_in_stage #(
		.MAX_YEAR (MAX_YEAR)
	) u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.day_in   (day_in),
		.month_in (month_in),
		.year_in  (year_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gdc_date_core #(
		.MAX_YEAR (MAX_YEAR)
	) u_date_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day_out    (day_out),
		.month_out  (month_out),
		.year_out   (year_out),
		.order_code (order_code),
		.status     (status)
	);

	`GDC_ASSERT_IMP(a_overflow_at_last, clk, arst_n, out_valid && (status == STAT_OVERFLOW),
		(day_out == DAYS_31) && (month_out == MON_DEC) && (year_out == YEAR_LAST),
		"overflow away from last date")
	`GDC_ASSERT_IMP(a_order_only_ok, clk, arst_n, out_valid && (status != STAT_OK),
		order_code == ORD_EQ, "order set on failed step")
	`GDC_ASSERT_IMP(a_date_sane, clk, arst_n, out_valid,
		(month_out >= MON_JAN) && (month_out <= MON_DEC) && (day_out >= DAY_FIRST)
		&& (year_out >= YEAR_FIRST) && (year_out <= YEAR_LAST), "stored date out of range")
	`GDC_ASSERT_NXT(a_reject_keeps_date, clk, arst_n, out_valid && out_ready,
		!(out_valid && (status == STAT_REJECT)) || ((day_out == $past(day_out))
		&& (month_out == $past(month_out)) && (year_out == $past(year_out))),
		"rejected load changed date")

endmodule

// File: design/gdc_in_stage.sv
// ----------------------------------------------------------------------------
// Gregorian date counter input stage
// Registers one input beat and precomputes the load date validity check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdc_in_stage
	import gdc_pkg::*;
#(
	parameter int unsigned MAX_YEAR = 3000
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [DAY_W-1:0]    day_in,
	input  logic [MONTH_W-1:0]  month_in,
	input  logic [YEAR_W-1:0]   year_in,
	input  logic                advance,
	output logic                valid_s1,
	output gdc_item_t           item_s1
);

	localparam logic [YEAR_W-1:0] YEAR_LAST = YEAR_W'(MAX_YEAR);

	logic             valid_q;
	logic             ok;
	logic [DAY_W-1:0] len;

	always_comb begin
		len = month_len(month_in, is_leap(year_in));
		ok  = (year_in >= YEAR_FIRST) && (year_in <= YEAR_LAST)
			&& (month_in >= MON_JAN) && (month_in <= MON_DEC)
			&& (day_in >= DAY_FIRST) && (day_in <= len);
	end

	assign in_ready = ~valid_q | advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action  <= action_t'(action);
			item_s1.day     <= day_in;
			item_s1.month   <= month_in;
			item_s1.year    <= year_in;
			item_s1.load_ok <= ok;
		end
	end

endmodule

// File: design/gdc_date_core.sv
// ----------------------------------------------------------------------------
// Gregorian date counter core
// Holds the stored date, applies tick, load and compare, registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdc_date_core
	import gdc_pkg::*;
#(
	parameter int unsigned MAX_YEAR = 3000
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  gdc_item_t           item_s1,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DAY_W-1:0]    day_out,
	output logic [MONTH_W-1:0]  month_out,
	output logic [YEAR_W-1:0]   year_out,
	output logic [1:0]          order_code,
	output logic [1:0]          status
);

	localparam logic [YEAR_W-1:0] YEAR_LAST = YEAR_W'(MAX_YEAR);

	logic [DAY_W-1:0]   cur_day_q;
	logic [MONTH_W-1:0] cur_month_q;
	logic [YEAR_W-1:0]  cur_year_q;
	logic               out_valid_q;

	logic [DAY_W-1:0]   nxt_day;
	logic [MONTH_W-1:0] nxt_month;
	logic [YEAR_W-1:0]  nxt_year;
	logic [1:0]         nxt_order;
	logic [1:0]         nxt_status;
	logic [DAY_W-1:0]   len;
	logic [20:0]        cur_key;
	logic [20:0]        in_key;

	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		len        = month_len(cur_month_q, is_leap(cur_year_q));
		cur_key    = {cur_year_q, cur_month_q, cur_day_q};
		in_key     = {item_s1.year, item_s1.month, item_s1.day};
		nxt_day    = cur_day_q;
		nxt_month  = cur_month_q;
		nxt_year   = cur_year_q;
		nxt_order  = ORD_EQ;
		nxt_status = STAT_OK;
		case (item_s1.action)
			ACT_TICK: begin
				if (cur_day_q >= len) begin
					if (cur_month_q >= MON_DEC) begin
						if (cur_year_q >= YEAR_LAST) begin
							nxt_status = STAT_OVERFLOW;
						end else begin
							nxt_year  = cur_year_q + YEAR_FIRST;
							nxt_month = MON_JAN;
							nxt_day   = DAY_FIRST;
						end
					end else begin
						nxt_month = cur_month_q + MON_JAN;
						nxt_day   = DAY_FIRST;
					end
				end else begin
					nxt_day = cur_day_q + DAY_FIRST;
				end
			end
			ACT_LOAD: begin
				if (item_s1.load_ok) begin
					nxt_day   = item_s1.day;
					nxt_month = item_s1.month;
					nxt_year  = item_s1.year;
				end else begin
					nxt_status = STAT_REJECT;
				end
			end
			ACT_CMP: begin
				if (cur_key < in_key) begin
					nxt_order = ORD_LESS;
				end else if (cur_key > in_key) begin
					nxt_order = ORD_GT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= DAY_FIRST;
			cur_month_q <= MON_JAN;
			cur_year_q  <= YEAR_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cur_day_q   <= nxt_day;
				cur_month_q <= nxt_month;
				cur_year_q  <= nxt_year;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			day_out    <= nxt_day;
			month_out  <= nxt_month;
			year_out   <= nxt_year;
			order_code <= nxt_order;
			status     <= nxt_status;
		end
	end

endmodule
